// ===== rtl/irs_pkg.sv =====
// ----------------------------------------------------------------------------
// irs_pkg
// Shared types and codes of the image resample interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package irs_pkg;

    localparam int COORD_W = 20;            // coordinate field width
    localparam int CRD_W   = COORD_W + 2;   // room for neighbor offsets
    localparam int PIX_W   = 24;

    typedef logic [PIX_W-1:0] t_pixel;

    localparam t_pixel WHITE = 24'hFFFFFF;

    // configuration register indexes
    localparam logic [1:0] CFG_METHOD = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    // method codes
    localparam logic [1:0] M_NEAREST  = 2'd0;
    localparam logic [1:0] M_BILINEAR = 2'd1;
    localparam logic [1:0] M_BICUBIC  = 2'd2;
    localparam logic [1:0] M_RSVD     = 2'd3;

    // item kinds
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // pass index of the final pass (vertical unless the plan is a single row)
    localparam logic [2:0] ROW_COL = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_FETCH,
        S_WAIT,
        S_CALC,
        S_WB,
        S_DONE
    } t_state;

    // neighbor fetch plans
    typedef enum logic [2:0] {
        PL_ONE,
        PL_ROW,
        PL_COL,
        PL_QUAD,
        PL_CUBE
    } t_plan;

    typedef struct packed {
        logic en;
        logic we;
    } t_store_ctl;

    typedef struct packed {
        logic en;
        logic half;     // extra 1/2 folded into the shift
    } t_mac_ctl;

endpackage

`default_nettype wire

// ===== rtl/irs_store.sv =====
// ----------------------------------------------------------------------------
// irs_store
// Single-port pixel memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module irs_store
    import irs_pkg::*;
#(
    parameter int AW    = 20,
    parameter int DEPTH = 1048576
) (
    input  wire logic          i_clk,
    input  wire t_store_ctl    i_ctl,
    input  wire logic [AW-1:0] i_addr,
    input  wire t_pixel        i_wdata,
    output t_pixel             o_rdata
);

    t_pixel mem [0:DEPTH-1];
    t_pixel r_q;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            if (i_ctl.we) begin
                mem[i_addr] <= i_wdata;
            end else begin
                r_q <= mem[i_addr];
            end
        end
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire

// ===== rtl/irs_mac.sv =====
// ----------------------------------------------------------------------------
// irs_mac
// Shared multiply, floor-shift and add unit: acc = base + floor(mul*t / 2^s).
// ----------------------------------------------------------------------------
`default_nettype none

module irs_mac
    import irs_pkg::*;
#(
    parameter int FRAC_BITS = 8,
    parameter int VW        = 24,
    parameter int TW        = 9
) (
    input  wire logic                 i_clk,
    input  wire t_mac_ctl             i_ctl,
    input  wire logic signed [VW-1:0] i_base,
    input  wire logic signed [VW-1:0] i_mul,
    input  wire logic signed [TW-1:0] i_t,
    output logic signed [VW-1:0]      o_acc
);

    localparam int PW = VW + TW;

    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] shifted;
    logic signed [VW-1:0] r_acc;
    logic signed [VW-1:0] n_acc;

    always_comb begin
        prod    = i_mul * i_t;
        // arithmetic shift is a floor for negative products
        shifted = i_ctl.half ? (prod >>> (FRAC_BITS + 1)) : (prod >>> FRAC_BITS);
        n_acc   = i_base + $signed(shifted[VW-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

// ===== rtl/image_resample_interpolator.sv =====
// ----------------------------------------------------------------------------
// image_resample_interpolator
// RGB pixel store sampled by nearest, bilinear or Catmull-Rom bicubic
// interpolation on fixed-point coordinates.
// ----------------------------------------------------------------------------
//  channel   signals                                   transfer when
//  command   start, busy, i_kind, i_coord_*, i_*_in    start && !busy
//  result    o_strobe, o_red_out/green/blue            o_strobe (one cycle)
//  config    i_cfg_valid, o_cfg_ready, index, data     i_cfg_valid && o_cfg_ready
//
//  A load writes the store on accept and busy stays low. A sample occupies the
//  block from accept to strobe: nearest reads one pixel, bilinear one (edge or
//  grid point), two (one axis) or four, bicubic sixteen, one store read per
//  neighbor, then one use of the shared multiply unit per cycle in calculation
//  (three per cubic pass, each pass followed by a writeback state). Synchronous
//  active-low reset restores control registers only. Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module image_resample_interpolator
    import irs_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int FRAC_BITS  = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_kind,
    input  wire logic [COORD_W-1:0] i_coord_x,
    input  wire logic [COORD_W-1:0] i_coord_y,
    input  wire logic [7:0]         i_red_in,
    input  wire logic [7:0]         i_green_in,
    input  wire logic [7:0]         i_blue_in,
    output logic                    o_strobe,
    output logic [7:0]              o_red_out,
    output logic [7:0]              o_green_out,
    output logic [7:0]              o_blue_out,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [10:0]        i_cfg_data
);

    localparam int F     = FRAC_BITS;
    localparam int CW    = CRD_W;
    localparam int VW    = F + 16;
    localparam int TW    = F + 1;
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int AW    = XW + YW;
    localparam int DEPTH = MAX_HEIGHT * (2 ** XW);

    localparam logic signed [CW-1:0] C_ONE  = CW'(1) <<< F;
    localparam logic signed [CW-1:0] C_HALF = CW'(1) <<< (F - 1);
    localparam logic signed [VW-1:0] C_MAXV = VW'(255) <<< F;

    // ---------------- helpers ----------------
    function automatic logic signed [CW-1:0] f_sext(input logic [COORD_W-1:0] v);
        return $signed({{(CW - COORD_W){v[COORD_W-1]}}, v});
    endfunction

    function automatic logic signed [CW-1:0] f_trunc(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] neg;
        neg = -v;
        return v[CW-1] ? -(neg >>> F) : (v >>> F);
    endfunction

    function automatic logic signed [CW-1:0] f_round(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] neg;
        neg = -v;
        return v[CW-1] ? -((neg + C_HALF) >>> F) : ((v + C_HALF) >>> F);
    endfunction

    function automatic logic signed [CW-1:0] f_ceil(input logic signed [CW-1:0] v);
        return v[CW-1] ? f_trunc(v) : ((v + C_ONE - CW'(1)) >>> F);
    endfunction

    function automatic logic signed [VW-1:0] f_chan(input t_pixel p, input logic [1:0] k);
        logic [7:0] c;
        case (k)
            2'd0:    c = p[23:16];
            2'd1:    c = p[15:8];
            default: c = p[7:0];
        endcase
        return $signed(VW'(c)) <<< F;
    endfunction

    function automatic logic signed [VW-1:0] f_clamp(input logic signed [VW-1:0] v);
        if (v > C_MAXV) begin
            return C_MAXV;
        end else if (v < 0) begin
            return '0;
        end
        return v;
    endfunction

    // ---------------- registers ----------------
    t_state r_state, n_state;
    logic [1:0]  r_method;
    logic [10:0] r_width, r_height;

    logic signed [CW-1:0] r_x, r_y;
    t_plan                r_plan;
    logic signed [CW-1:0] r_bx, r_by;
    logic signed [TW-1:0] r_tx, r_ty;

    logic [3:0] r_n;
    logic [1:0] r_ch;
    logic [2:0] r_row;
    logic [1:0] r_step;

    logic       r_cap_vld;
    logic       r_cap_white;
    logic [1:0] r_cap_row, r_cap_col;

    t_pixel               r_buf [4][4];
    logic signed [VW-1:0] r_rowres [4];
    logic [7:0]           r_out [3];

    // ---------------- size limits ----------------
    logic signed [CW-1:0] w_eff, h_eff;
    always_comb begin
        w_eff = (CW'(r_width) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : $signed(CW'(r_width));
        h_eff = (CW'(r_height) > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : $signed(CW'(r_height));
    end

    // ---------------- load path ----------------
    logic signed [CW-1:0] lx, ly;
    logic                 load_in;
    logic                 accept;
    always_comb begin
        lx      = f_trunc(f_sext(i_coord_x));
        ly      = f_trunc(f_sext(i_coord_y));
        load_in = (lx >= 0) && (ly >= 0) && (lx < w_eff) && (ly < h_eff);
        accept  = start && (r_state == S_IDLE);
    end

    // ---------------- setup ----------------
    logic signed [CW-1:0] x1, x2, y1, y2;
    logic signed [CW-1:0] s_bx, s_by;
    t_plan                s_plan;
    logic signed [CW-1:0] s_tx, s_ty;
    always_comb begin
        x1   = f_trunc(r_x);
        y1   = f_trunc(r_y);
        x2   = f_ceil(r_x);
        y2   = f_ceil(r_y);
        s_tx = r_x - (x1 <<< F);
        s_ty = r_y - (y1 <<< F);
        case (r_method)
            M_NEAREST: begin
                s_plan = PL_ONE;
                s_bx   = f_round(r_x);
                s_by   = f_round(r_y);
            end
            M_BILINEAR: begin
                s_bx = x1;
                s_by = y1;
                // right/bottom edge or exact grid point: take the pixel itself
                if ((x2 > w_eff) || (y2 > h_eff) || ((x2 == x1) && (y2 == y1))) begin
                    s_plan = PL_ONE;
                end else if (x2 == x1) begin
                    s_plan = PL_COL;
                end else if (y2 == y1) begin
                    s_plan = PL_ROW;
                end else begin
                    s_plan = PL_QUAD;
                end
            end
            default: begin
                s_plan = PL_CUBE;
                s_bx   = x1 - CW'(1);
                s_by   = y1 - CW'(1);
            end
        endcase
    end

    // ---------------- fetch addressing ----------------
    logic [1:0]           dx, dy, f_row, f_col;
    logic [3:0]           last_n;
    logic signed [CW-1:0] px, py;
    logic                 f_in;
    always_comb begin
        dx = '0; dy = '0; f_row = '0; f_col = '0; last_n = '0;
        case (r_plan)
            PL_ROW: begin
                dx = {1'b0, r_n[0]}; f_col = {1'b0, r_n[0]}; last_n = 4'd1;
            end
            PL_COL: begin
                dy = {1'b0, r_n[0]}; f_col = {1'b0, r_n[0]}; last_n = 4'd1;
            end
            PL_QUAD: begin
                dx = {1'b0, r_n[0]}; dy = {1'b0, r_n[1]};
                f_col = {1'b0, r_n[0]}; f_row = {1'b0, r_n[1]}; last_n = 4'd3;
            end
            PL_CUBE: begin
                dx = r_n[1:0]; dy = r_n[3:2];
                f_col = r_n[1:0]; f_row = r_n[3:2]; last_n = 4'd15;
            end
            default: begin
                last_n = 4'd0;
            end
        endcase
        px   = r_bx + $signed({{(CW - 2){1'b0}}, dx});
        py   = r_by + $signed({{(CW - 2){1'b0}}, dy});
        f_in = (px >= 0) && (py >= 0) && (px < w_eff) && (py < h_eff);
    end

    // ---------------- pass operands ----------------
    logic [1:0]           rsel;
    logic                 col_pass, cubic, op_last;
    logic signed [VW-1:0] a, b, c, d;
    logic signed [VW-1:0] mac_base, mac_mul, mac_acc, wb_val;
    logic signed [TW-1:0] mac_t;
    t_mac_ctl             mac_ctl;
    always_comb begin
        rsel     = r_row[2] ? 2'd0 : r_row[1:0];
        col_pass = (r_row == ROW_COL);
        cubic    = (r_plan == PL_CUBE);
        if (col_pass && ((r_plan == PL_CUBE) || (r_plan == PL_QUAD))) begin
            a = r_rowres[0]; b = r_rowres[1]; c = r_rowres[2]; d = r_rowres[3];
        end else begin
            a = f_chan(r_buf[rsel][0], r_ch);
            b = f_chan(r_buf[rsel][1], r_ch);
            c = f_chan(r_buf[rsel][2], r_ch);
            d = f_chan(r_buf[rsel][3], r_ch);
        end
        mac_t = (col_pass && (r_plan != PL_ROW)) ? r_ty : r_tx;
        mac_ctl.en   = (r_state == S_CALC) && (r_plan != PL_ONE);
        mac_ctl.half = 1'b0;
        if (cubic) begin
            case (r_step)
                2'd0: begin
                    mac_base = (a <<< 1) - (b <<< 2) - b + (c <<< 2) - d;
                    mac_mul  = ((b - c) <<< 1) + (b - c) + d - a;
                end
                2'd1: begin
                    mac_base = c - a;
                    mac_mul  = mac_acc;
                end
                default: begin
                    mac_base     = b;
                    mac_mul      = mac_acc;
                    mac_ctl.half = 1'b1;
                end
            endcase
        end else begin
            mac_base = a;
            mac_mul  = b - a;
        end
        op_last = !cubic || (r_step == 2'd2);
        wb_val  = cubic ? f_clamp(mac_acc) : mac_acc;
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept && (i_kind == KIND_SAMPLE)) n_state = S_SETUP;
            S_SETUP: n_state = S_FETCH;
            S_FETCH: if (r_n == last_n) n_state = S_WAIT;
            S_WAIT:  n_state = S_CALC;
            S_CALC: begin
                if (r_plan == PL_ONE) begin
                    n_state = S_DONE;
                end else if (op_last) begin
                    n_state = S_WB;
                end
            end
            S_WB:    n_state = (col_pass && (r_ch == 2'd2)) ? S_DONE : S_CALC;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    t_store_ctl          st_ctl;
    logic [AW-1:0]       st_addr;
    t_pixel              st_rdata;
    always_comb begin
        st_ctl  = '0;
        st_addr = {py[YW-1:0], px[XW-1:0]};
        case (r_state)
            S_IDLE: begin
                st_addr   = {ly[YW-1:0], lx[XW-1:0]};
                st_ctl.we = accept && (i_kind == KIND_LOAD) && load_in;
                st_ctl.en = st_ctl.we;
            end
            S_FETCH: st_ctl.en = f_in;
            default: ;
        endcase
    end

    irs_store #(
        .AW    (AW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_ctl   (st_ctl),
        .i_addr  (st_addr),
        .i_wdata ({i_red_in, i_green_in, i_blue_in}),
        .o_rdata (st_rdata)
    );

    irs_mac #(
        .FRAC_BITS (F),
        .VW        (VW),
        .TW        (TW)
    ) u_mac (
        .i_clk  (i_clk),
        .i_ctl  (mac_ctl),
        .i_base (mac_base),
        .i_mul  (mac_mul),
        .i_t    (mac_t),
        .o_acc  (mac_acc)
    );

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_method  <= M_BICUBIC;
            r_width   <= 11'd1024;
            r_height  <= 11'd1024;
            r_n       <= '0;
            r_ch      <= '0;
            r_row     <= '0;
            r_step    <= '0;
            r_cap_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cap_vld <= (r_state == S_FETCH);
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_METHOD: if (i_cfg_data[1:0] != M_RSVD) r_method <= i_cfg_data[1:0];
                    CFG_WIDTH:  r_width  <= i_cfg_data;
                    CFG_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_SETUP: r_n <= '0;
                S_FETCH: r_n <= r_n + 4'd1;
                S_WAIT: begin
                    r_ch   <= '0;
                    r_step <= '0;
                    r_row  <= ((r_plan == PL_CUBE) || (r_plan == PL_QUAD)) ? 3'd0 : ROW_COL;
                end
                S_CALC: if (!op_last) r_step <= r_step + 2'd1;
                S_WB: begin
                    r_step <= '0;
                    if (col_pass) begin
                        r_ch  <= r_ch + 2'd1;
                        r_row <= ((r_plan == PL_CUBE) || (r_plan == PL_QUAD)) ? 3'd0 : ROW_COL;
                    end else if (((r_plan == PL_QUAD) && (r_row == 3'd1)) || (r_row == 3'd3)) begin
                        r_row <= ROW_COL;
                    end else begin
                        r_row <= r_row + 3'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x <= f_sext(i_coord_x);
            r_y <= f_sext(i_coord_y);
        end
        if (r_state == S_SETUP) begin
            r_plan <= s_plan;
            r_bx   <= s_bx;
            r_by   <= s_by;
            r_tx   <= s_tx[TW-1:0];
            r_ty   <= s_ty[TW-1:0];
        end
        if (r_state == S_FETCH) begin
            r_cap_white <= !f_in;
            r_cap_row   <= f_row;
            r_cap_col   <= f_col;
        end
        if (r_cap_vld) begin
            r_buf[r_cap_row][r_cap_col] <= r_cap_white ? WHITE : st_rdata;
        end
        if ((r_state == S_CALC) && (r_plan == PL_ONE)) begin
            r_out[0] <= r_buf[0][0][23:16];
            r_out[1] <= r_buf[0][0][15:8];
            r_out[2] <= r_buf[0][0][7:0];
        end
        if (r_state == S_WB) begin
            if (col_pass) begin
                r_out[r_ch] <= wb_val[F+7:F];
            end else begin
                r_rowres[r_row[1:0]] <= wb_val;
            end
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_strobe    = (r_state == S_DONE);
    assign o_red_out   = r_out[0];
    assign o_green_out = r_out[1];
    assign o_blue_out  = r_out[2];
    assign o_cfg_ready = 1'b1;

    // ---------------- assertions ----------------
    a_store_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_ctl.we |-> !busy)
        else $error("store written during a sample");

    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_kind == KIND_SAMPLE)) |=> busy)
        else $error("sample accepted but block not busy");

    a_load_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_kind == KIND_LOAD)) |=> !busy && !o_strobe)
        else $error("load caused activity");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe && !busy)
        else $error("result strobe longer than one cycle");

    a_mac_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_ctl.en |-> (r_state == S_CALC) && (r_row <= ROW_COL))
        else $error("multiply unit used outside a pass");

endmodule

`default_nettype wire
